// ----- sv/cbd_pkg.sv -----
package cbd_pkg;

   localparam int DATA_W = 32;
   localparam int CLK_W = 12;
   localparam int CNT_W = 3;
   localparam int DIV_CNT_W = $clog2(DATA_W + 1);

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 104;

   localparam logic [0:0] REG_MONITOR_ENABLE = 1'b0;
   localparam logic [0:0] REG_CLOCK_LIMIT = 1'b1;

   localparam logic [CLK_W-1:0] CLOCK_LIMIT_RESET = 12'd4095;

   localparam logic [CNT_W-1:0] PERIOD_QUALIFY = 3'd5;
   localparam logic [DATA_W-1:0] ACTIVE_SCALE = 32'd100;
   localparam logic [DATA_W-1:0] LS_LIMIT = 32'd40;
   localparam logic [DATA_W-1:0] TOTAL_LIMIT = 32'd80;
   localparam logic [DATA_W-1:0] ARITH_WEIGHT = 32'd10;
   localparam logic [DATA_W-1:0] LS_WEIGHT = 32'd14;

   localparam logic [1:0] POLICY_NONE = 2'd0;
   localparam logic [1:0] POLICY_SAMPLING = 2'd1;
   localparam logic [1:0] POLICY_RESTORE = 2'd2;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/cbd_divider.sv -----
module cbd_divider
   import cbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DATA_W+1:0]    trial;

   assign trial = {1'b0, rem_ff, quo_ff[DATA_W-1]} - {2'b00, divisor_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         divisor_in = div_req.divisor;
         cnt_in = DIV_CNT_W'(DATA_W);
      end else if (cnt_ff != '0) begin
         if (trial[DATA_W+1]) begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(cnt_ff) == DIV_CNT_W'(1))
      else $error("divider done without final step");

   a_start_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_req.divisor != '0)
      else $error("divide started with zero divisor");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (cnt_ff == '0) || (cnt_ff == DIV_CNT_W'(1)))
      else $error("divide restarted while busy");

endmodule

// ----- sv/gpu_counter_boost_detector_unit.sv -----
// Activity-counter boost detector.
// req channel: one request per shader core per sampling period; tlast marks
// the last core. tdata carries the clock, the mapped and context flags and
// the four activity counters of that core, which are summed with wrap.
// rsp channel: exactly one result per last-core request, none otherwise.
// csr port: register 0 is the monitor enable, register 1 the clock limit;
// write only while no last-core request is in flight.
// A non-last request takes one cycle and may be taken back to back.
// A last-core request holds the block in S_CLOCK and S_DONE when monitoring
// or sampling is off or the context or buffer is missing, adds S_DIV_BASE
// and S_TEST when active/100 is zero and all division states otherwise:
// one shared radix-2 divider forms active/100, then the three utilizations
// in turn. The result turns valid at the edge that makes the block ready.
// req_tready is low from the last-core request until its result is loaded
// into the output register. A stalled receiver holds the result there; the
// block keeps taking non-last requests, and a further last-core request
// waits finished until the register frees.
// Synchronous reset clears sums, flags, counters and both registers to
// their defaults (monitor disabled, clock limit 4095).
module gpu_counter_boost_detector_unit
   import cbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // gpu_clock[11:0], counters_mapped[12], context_ready[13],
   // pipe_active[45:14], arith_count[77:46], loadstore_count[109:78],
   // texture_count[141:110], zero[143:142]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sampling_on[0], boost_clock[1], policy_change[3:2], counter_cmd[5:4],
   // status[6], util_arith[38:7], util_loadstore[70:39],
   // util_texture[102:71], zero[103]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CLK_W-1:0]      csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CLOCK    = 8'b0000_0010,
      S_DIV_BASE = 8'b0000_0100,
      S_DIV_A    = 8'b0000_1000,
      S_DIV_L    = 8'b0001_0000,
      S_DIV_T    = 8'b0010_0000,
      S_TEST     = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic              enable_ff;
   logic [CLK_W-1:0]  limit_ff;

   logic [DATA_W-1:0] sum_active_ff, sum_active_in;
   logic [DATA_W-1:0] sum_arith_ff, sum_arith_in;
   logic [DATA_W-1:0] sum_ls_ff, sum_ls_in;
   logic [DATA_W-1:0] sum_tex_ff, sum_tex_in;

   logic [CLK_W-1:0]  clk_ff, clk_in;
   logic              mapped_ff, mapped_in;
   logic              ctx_ff, ctx_in;

   logic              sampling_ff, sampling_in;
   logic              boost_ff, boost_in;
   logic [CNT_W-1:0]  below_ff, below_in;
   logic [CNT_W-1:0]  start_cnt_ff, start_cnt_in;
   logic [CNT_W-1:0]  stop_cnt_ff, stop_cnt_in;

   logic [1:0]        policy_ff, policy_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic              status_ff, status_in;
   logic [DATA_W-1:0] ua_ff, ua_in;
   logic [DATA_W-1:0] ul_ff, ul_in;
   logic [DATA_W-1:0] ut_ff, ut_in;
   logic [DATA_W-1:0] scale_ff, scale_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic              req_fire;
   logic [CNT_W-1:0]  below_inc;
   logic [CNT_W-1:0]  start_inc;
   logic [CNT_W-1:0]  stop_inc;
   logic [DATA_W-1:0] total;
   logic [DATA_W-1:0] arith_weighted;
   logic [DATA_W-1:0] ls_weighted;
   logic              test_pass;
   logic              out_free;

   cbd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign below_inc = below_ff + 1'b1;
   assign start_inc = start_cnt_ff + 1'b1;
   assign stop_inc = stop_cnt_ff + 1'b1;

   assign total = ua_ff + ul_ff + ut_ff;
   assign arith_weighted = ua_ff * ARITH_WEIGHT;
   assign ls_weighted = ul_ff * LS_WEIGHT;
   assign test_pass = (arith_weighted > ls_weighted) && (ul_ff < LS_LIMIT)
                      && (total > TOTAL_LIMIT) && !total[DATA_W-1];

   always_comb begin
      state_in = state_ff;
      sum_active_in = sum_active_ff;
      sum_arith_in = sum_arith_ff;
      sum_ls_in = sum_ls_ff;
      sum_tex_in = sum_tex_ff;
      clk_in = clk_ff;
      mapped_in = mapped_ff;
      ctx_in = ctx_ff;
      sampling_in = sampling_ff;
      boost_in = boost_ff;
      below_in = below_ff;
      start_cnt_in = start_cnt_ff;
      stop_cnt_in = stop_cnt_ff;
      policy_in = policy_ff;
      cmd_in = cmd_ff;
      status_in = status_ff;
      ua_in = ua_ff;
      ul_in = ul_ff;
      ut_in = ut_ff;
      scale_in = scale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      div_req.start = 1'b0;
      div_req.dividend = sum_active_ff;
      div_req.divisor = ACTIVE_SCALE;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sum_active_in = sum_active_ff + req_tdata[45:14];
               sum_arith_in = sum_arith_ff + req_tdata[77:46];
               sum_ls_in = sum_ls_ff + req_tdata[109:78];
               sum_tex_in = sum_tex_ff + req_tdata[141:110];
               clk_in = req_tdata[11:0];
               mapped_in = req_tdata[12];
               ctx_in = req_tdata[13];
               if (req_tlast) begin
                  state_in = S_CLOCK;
               end
            end
         end
         S_CLOCK: begin
            policy_in = POLICY_NONE;
            cmd_in = CMD_NONE;
            status_in = STATUS_OK;
            ua_in = '0;
            ul_in = '0;
            ut_in = '0;
            state_in = S_DONE;
            if (enable_ff) begin
               if (!sampling_ff && clk_ff >= limit_ff) begin
                  policy_in = POLICY_SAMPLING;
                  sampling_in = 1'b1;
                  cmd_in = mapped_ff ? CMD_NONE : CMD_START;
                  start_cnt_in = '0;
                  below_in = '0;
               end else if (sampling_ff && clk_ff < limit_ff) begin
                  below_in = below_inc;
                  if (below_inc > PERIOD_QUALIFY) begin
                     cmd_in = mapped_ff ? CMD_STOP : CMD_NONE;
                     sampling_in = 1'b0;
                     policy_in = POLICY_RESTORE;
                     below_in = '0;
                     boost_in = 1'b0;
                  end
               end
               if (sampling_in) begin
                  if (!ctx_ff || !mapped_ff) begin
                     status_in = STATUS_FAIL;
                  end else begin
                     div_req.start = 1'b1;
                     state_in = S_DIV_BASE;
                  end
               end
            end
         end
         S_DIV_BASE: begin
            if (div_rsp.done) begin
               scale_in = div_rsp.quotient;
               if (div_rsp.quotient == '0) begin
                  state_in = S_TEST;
               end else begin
                  div_req.start = 1'b1;
                  div_req.dividend = sum_arith_ff;
                  div_req.divisor = div_rsp.quotient;
                  state_in = S_DIV_A;
               end
            end
         end
         S_DIV_A: begin
            div_req.dividend = sum_ls_ff;
            div_req.divisor = scale_ff;
            if (div_rsp.done) begin
               ua_in = div_rsp.quotient;
               div_req.start = 1'b1;
               state_in = S_DIV_L;
            end
         end
         S_DIV_L: begin
            div_req.dividend = sum_tex_ff;
            div_req.divisor = scale_ff;
            if (div_rsp.done) begin
               ul_in = div_rsp.quotient;
               div_req.start = 1'b1;
               state_in = S_DIV_T;
            end
         end
         S_DIV_T: begin
            if (div_rsp.done) begin
               ut_in = div_rsp.quotient;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (test_pass) begin
               start_cnt_in = start_inc;
               stop_cnt_in = '0;
               if (start_inc > PERIOD_QUALIFY) begin
                  boost_in = 1'b1;
                  start_cnt_in = '0;
               end
            end else begin
               stop_cnt_in = stop_inc;
               start_cnt_in = '0;
               if (stop_inc > PERIOD_QUALIFY) begin
                  boost_in = 1'b0;
                  stop_cnt_in = '0;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, ut_ff, ul_ff, ua_ff, status_ff, cmd_ff, policy_ff,
                              boost_ff, sampling_ff};
               sum_active_in = '0;
               sum_arith_in = '0;
               sum_ls_in = '0;
               sum_tex_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b0;
         limit_ff <= CLOCK_LIMIT_RESET;
         sum_active_ff <= '0;
         sum_arith_ff <= '0;
         sum_ls_ff <= '0;
         sum_tex_ff <= '0;
         sampling_ff <= 1'b0;
         boost_ff <= 1'b0;
         below_ff <= '0;
         start_cnt_ff <= '0;
         stop_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == REG_MONITOR_ENABLE) begin
            enable_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == REG_CLOCK_LIMIT) begin
            limit_ff <= csr_wdata;
         end
         sum_active_ff <= sum_active_in;
         sum_arith_ff <= sum_arith_in;
         sum_ls_ff <= sum_ls_in;
         sum_tex_ff <= sum_tex_in;
         sampling_ff <= sampling_in;
         boost_ff <= boost_in;
         below_ff <= below_in;
         start_cnt_ff <= start_cnt_in;
         stop_cnt_ff <= stop_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clk_ff <= clk_in;
      mapped_ff <= mapped_in;
      ctx_ff <= ctx_in;
      policy_ff <= policy_in;
      cmd_ff <= cmd_in;
      status_ff <= status_in;
      ua_ff <= ua_in;
      ul_ff <= ul_in;
      ut_ff <= ut_in;
      scale_ff <= scale_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_boost_needs_sampling: assert property (@(posedge clock) disable iff (reset)
      boost_ff |-> sampling_ff)
      else $error("boost flag set while sampling is off");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("request taken during period close");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (below_ff <= PERIOD_QUALIFY) && (start_cnt_ff <= PERIOD_QUALIFY)
      && (stop_cnt_ff <= PERIOD_QUALIFY))
      else $error("qualify counter out of range");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (sum_active_ff == '0) && (sum_tex_ff == '0))
      else $error("sums not cleared after period");

endmodule
